// ----- rtl/lpp_pkg.sv -----
// Shared types, constants and register codes of the linear pixel predictor.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package lpp_pkg;

    localparam int PIX_W         = 8;
    localparam int COEF_W        = 5;
    localparam int SHIFT_W       = 3;
    localparam int WIDTH_W       = 13;
    localparam int ROW_W         = 16;
    localparam int COL_OUT_W     = 12;
    localparam int SUM_W         = 16;
    localparam int CFG_ADDR_W    = 3;
    localparam int DEF_MAX_WIDTH = 4096;

    localparam logic [WIDTH_W-1:0] RST_IMAGE_WIDTH = WIDTH_W'(640);
    localparam logic [COEF_W-1:0]  RST_COEF_LEFT   = COEF_W'(1);
    localparam logic [ROW_W-1:0]   ROW_MAX         = {ROW_W{1'b1}};

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_IMAGE_WIDTH    = 3'd0,
        CFG_COEF_LEFT      = 3'd1,
        CFG_COEF_UP        = 3'd2,
        CFG_COEF_LEFT_LEFT = 3'd3,
        CFG_COEF_UP_LEFT   = 3'd4,
        CFG_COEF_UP_UP     = 3'd5,
        CFG_COEF_UP_RIGHT  = 3'd6,
        CFG_SUM_SHIFT      = 3'd7
    } cfg_idx_t;

    // red in the lowest byte, as on the input bus
    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } pixel_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] left;
        logic signed [COEF_W-1:0] up;
        logic signed [COEF_W-1:0] left_left;
        logic signed [COEF_W-1:0] up_left;
        logic signed [COEF_W-1:0] up_up;
        logic signed [COEF_W-1:0] up_right;
        logic [SHIFT_W-1:0]       shift;
    } pred_cfg_t;

    localparam pred_cfg_t RST_PRED_CFG = '{
        left:      RST_COEF_LEFT,
        up:        '0,
        left_left: '0,
        up_left:   '0,
        up_up:     '0,
        up_right:  '0,
        shift:     '0
    };

    // result item, red residual in the lowest bits, padded to whole bytes
    typedef struct packed {
        logic [3:0]           pad;
        logic [ROW_W-1:0]     row;
        logic [COL_OUT_W-1:0] col;
        logic [PIX_W-1:0]     res_blue;
        logic [PIX_W-1:0]     res_green;
        logic [PIX_W-1:0]     res_red;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/lpp_line_buf.sv -----
// Two line stores (row above, row two above) with registered reads.
// The row-above store has two read ports for the up and up-right taps. Uses lpp_pkg.
`default_nettype none

module lpp_line_buf #(
    parameter int MAX_WIDTH = lpp_pkg::DEF_MAX_WIDTH,
    parameter int ADDR_W    = $clog2(MAX_WIDTH)
) (
    input  wire logic                aclk,
    input  wire logic                rd_en,
    input  wire logic [ADDR_W-1:0]   rd_addr,
    input  wire logic [ADDR_W-1:0]   rd_addr_p1,
    input  wire logic                wr_en,
    input  wire logic [ADDR_W-1:0]   wr_addr,
    input  wire lpp_pkg::pixel_t     wr_above,
    input  wire lpp_pkg::pixel_t     wr_two_above,
    output lpp_pkg::pixel_t          rd_up,
    output lpp_pkg::pixel_t          rd_up_right,
    output lpp_pkg::pixel_t          rd_up_up
);
    import lpp_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    pixel_t above_mem [DEPTH];
    pixel_t two_above_mem [DEPTH];

    pixel_t up_reg, up_right_reg, up_up_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            above_mem[wr_addr] <= wr_above;
        end
        if (rd_en) begin
            up_reg       <= above_mem[rd_addr];
            up_right_reg <= above_mem[rd_addr_p1];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            two_above_mem[wr_addr] <= wr_two_above;
        end
        if (rd_en) begin
            up_up_reg <= two_above_mem[rd_addr];
        end
    end

    assign rd_up       = up_reg;
    assign rd_up_right = up_right_reg;
    assign rd_up_up    = up_up_reg;

endmodule

`default_nettype wire

// ----- rtl/lpp_chan_pred.sv -----
// One color channel: six-tap weighted sum into a register, then shift,
// clamp to 0..255 and residual modulo 256. Uses lpp_pkg.
`default_nettype none

module lpp_chan_pred (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire lpp_pkg::pred_cfg_t        cfg,
    input  wire logic [lpp_pkg::PIX_W-1:0] pix_l,
    input  wire logic [lpp_pkg::PIX_W-1:0] pix_u,
    input  wire logic [lpp_pkg::PIX_W-1:0] pix_ll,
    input  wire logic [lpp_pkg::PIX_W-1:0] pix_ul,
    input  wire logic [lpp_pkg::PIX_W-1:0] pix_uu,
    input  wire logic [lpp_pkg::PIX_W-1:0] pix_ur,
    input  wire logic [lpp_pkg::PIX_W-1:0] pix_cur,
    output logic      [lpp_pkg::PIX_W-1:0] residual
);
    import lpp_pkg::*;

    function automatic logic signed [SUM_W-1:0] tap(
        input logic signed [COEF_W-1:0] c,
        input logic [PIX_W-1:0]         p
    );
        logic signed [SUM_W-1:0] cw;
        logic signed [SUM_W-1:0] pw;
        cw = SUM_W'(c);
        pw = $signed({{(SUM_W-PIX_W){1'b0}}, p});
        return cw * pw;
    endfunction

    logic signed [SUM_W-1:0] sum_next, sum_reg;
    logic [PIX_W-1:0]        cur_reg;
    logic signed [SUM_W-1:0] shifted;
    logic [PIX_W-1:0]        pred;

    assign sum_next = tap(cfg.left, pix_l) + tap(cfg.up, pix_u)
                    + tap(cfg.left_left, pix_ll) + tap(cfg.up_left, pix_ul)
                    + tap(cfg.up_up, pix_uu) + tap(cfg.up_right, pix_ur);

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sum_next;
            cur_reg <= pix_cur;
        end
    end

    // arithmetic shift rounds toward minus infinity
    assign shifted = sum_reg >>> cfg.shift;

    always_comb begin
        if (shifted[SUM_W-1]) begin
            pred = '0;
        end else if (|shifted[SUM_W-2:PIX_W]) begin
            pred = {PIX_W{1'b1}};
        end else begin
            pred = shifted[PIX_W-1:0];
        end
    end

    assign residual = cur_reg - pred;

endmodule

`default_nettype wire

// ----- rtl/lpp_out_skid.sv -----
// Output register plus one skid entry for result items.
// Ready toward the pipeline is registered. Uses lpp_pkg.
`default_nettype none

module lpp_out_skid (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire lpp_pkg::result_t  push_data,
    output logic                   push_ready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output lpp_pkg::result_t       m_data
);
    import lpp_pkg::*;

    logic    out_valid_reg, skid_valid_reg;
    result_t out_data_reg, skid_data_reg;
    logic    pop;

    assign pop = out_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_data_reg <= push_data;
            end else begin
                skid_data_reg <= push_data;
            end
        end
    end

    assign push_ready = !skid_valid_reg;
    assign m_tvalid   = out_valid_reg;
    assign m_data     = out_data_reg;

endmodule

`default_nettype wire

// ----- rtl/linear_pixel_prediction_residual.sv -----
// Six-tap causal linear predictor residual for an RGB raster stream.
// An interior pixel passes the stage-1, stage-2 and output registers to m_tvalid.
// Throughput: one pixel per cycle while the output skid entry is empty, set by
// one write per store, three reads and a combinational tap sum per channel.
// Reset (synchronous, aresetn low): config back to defaults; position, neighbor and
// valid registers cleared; line stores not cleared, undefined until written.
`default_nettype none

module linear_pixel_prediction_residual #(
    parameter int MAX_WIDTH = lpp_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wen,
    input  wire logic [lpp_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [lpp_pkg::WIDTH_W-1:0]    cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [23:0]                    s_tdata,  // red, green, blue
    input  wire logic [0:0]                     s_tuser,  // frame_start
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // residual_red, residual_green, residual_blue, pixel_column, pixel_row, zero pad
    output logic [55:0]                         m_tdata
);
    import lpp_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 2 > 14) ? CW + 2 : 14;

    // ---------------- configuration ----------------
    logic [WIDTH_W-1:0] image_width_reg;
    pred_cfg_t          pcfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg    <= RST_IMAGE_WIDTH;
            pcfg_reg           <= RST_PRED_CFG;
        end else if (cfg_wen) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_IMAGE_WIDTH:    image_width_reg    <= cfg_wdata;
                CFG_COEF_LEFT:      pcfg_reg.left      <= cfg_wdata[COEF_W-1:0];
                CFG_COEF_UP:        pcfg_reg.up        <= cfg_wdata[COEF_W-1:0];
                CFG_COEF_LEFT_LEFT: pcfg_reg.left_left <= cfg_wdata[COEF_W-1:0];
                CFG_COEF_UP_LEFT:   pcfg_reg.up_left   <= cfg_wdata[COEF_W-1:0];
                CFG_COEF_UP_UP:     pcfg_reg.up_up     <= cfg_wdata[COEF_W-1:0];
                CFG_COEF_UP_RIGHT:  pcfg_reg.up_right  <= cfg_wdata[COEF_W-1:0];
                CFG_SUM_SHIFT:      pcfg_reg.shift     <= cfg_wdata[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage 0: position ----------------
    logic en, s_accept;
    logic frame_start;
    pixel_t s_pix;

    assign s_tready    = en;
    assign s_accept    = s_tvalid && en;
    assign frame_start = s_tuser[0];
    assign s_pix       = pixel_t'(s_tdata);

    logic [CW-1:0]    col_reg, col_next, col0, col0_p1;
    logic [ROW_W-1:0] row_reg, row_next, row0;
    logic [EW-1:0]    iw_w, max_w, eff_w, col0_w;
    logic             last0, interior0;

    assign max_w  = EW'(MAX_WIDTH);
    assign iw_w   = EW'(image_width_reg);
    assign eff_w  = (iw_w == '0) ? EW'(1) : ((iw_w > max_w) ? max_w : iw_w);

    assign col0    = frame_start ? '0 : col_reg;
    assign row0    = frame_start ? '0 : row_reg;
    assign col0_w  = EW'(col0);
    assign col0_p1 = CW'(col0_w + EW'(1));

    assign last0     = (col0_w + EW'(1)) >= eff_w;
    assign interior0 = (row0 >= ROW_W'(2)) && (col0_w >= EW'(2))
                    && ((col0_w + EW'(2)) < eff_w);

    always_comb begin
        if (last0) begin
            col_next = '0;
            row_next = (row0 == ROW_MAX) ? row0 : row0 + ROW_W'(1);
        end else begin
            col_next = col0_p1;
            row_next = row0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- stage 1: taps ----------------
    logic             v1_reg, fs1_reg, int1_reg;
    logic [CW-1:0]    col1_reg;
    logic [ROW_W-1:0] row1_reg;
    pixel_t           cur1_reg;
    logic             fwd_up_reg, fwd_ur_reg;
    pixel_t           lw_above_reg, lw_two_reg;
    pixel_t           left_reg, left_left_reg, up_prev_reg;
    pixel_t           rd_up, rd_ur, rd_uu;
    pixel_t           up1, ur1, uu1, l1, ll1, ul1;
    logic             wr_en;

    assign wr_en = en && v1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg     <= 1'b0;
            fwd_up_reg <= 1'b0;
            fwd_ur_reg <= 1'b0;
        end else if (en) begin
            v1_reg     <= s_accept;
            // the item now in stage 1 writes its column at this same edge
            fwd_up_reg <= s_accept && v1_reg && (col1_reg == col0);
            fwd_ur_reg <= s_accept && v1_reg && (col1_reg == col0_p1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fs1_reg  <= frame_start;
            int1_reg <= interior0;
            col1_reg <= col0;
            row1_reg <= row0;
            cur1_reg <= s_pix;
        end
        if (wr_en) begin
            lw_above_reg <= cur1_reg;
            lw_two_reg   <= up1;
        end
    end

    lpp_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .ADDR_W    (CW)
    ) u_line_buf (
        .aclk         (aclk),
        .rd_en        (s_accept),
        .rd_addr      (col0),
        .rd_addr_p1   (col0_p1),
        .wr_en        (wr_en),
        .wr_addr      (col1_reg),
        .wr_above     (cur1_reg),
        .wr_two_above (up1),
        .rd_up        (rd_up),
        .rd_up_right  (rd_ur),
        .rd_up_up     (rd_uu)
    );

    assign up1 = fwd_up_reg ? lw_above_reg : rd_up;
    assign ur1 = fwd_ur_reg ? lw_above_reg : rd_ur;
    assign uu1 = fwd_up_reg ? lw_two_reg   : rd_uu;

    // frame start clears the row-local neighbors before use
    assign l1  = fs1_reg ? '0 : left_reg;
    assign ll1 = fs1_reg ? '0 : left_left_reg;
    assign ul1 = fs1_reg ? '0 : up_prev_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg      <= '0;
            left_left_reg <= '0;
            up_prev_reg   <= '0;
        end else if (wr_en) begin
            left_left_reg <= l1;
            left_reg      <= cur1_reg;
            up_prev_reg   <= up1;
        end
    end

    // ---------------- stage 2: prediction ----------------
    logic                 v2_reg;
    logic [COL_OUT_W-1:0] col2_reg;
    logic [ROW_W-1:0]     row2_reg;
    logic [EW-1:0]        col1_w;
    logic [PIX_W-1:0]     res_r, res_g, res_b;

    assign col1_w = EW'(col1_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg && int1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            col2_reg <= col1_w[COL_OUT_W-1:0];
            row2_reg <= row1_reg;
        end
    end

    lpp_chan_pred u_pred_red (
        .aclk     (aclk),
        .en       (en),
        .cfg      (pcfg_reg),
        .pix_l    (l1.red),
        .pix_u    (up1.red),
        .pix_ll   (ll1.red),
        .pix_ul   (ul1.red),
        .pix_uu   (uu1.red),
        .pix_ur   (ur1.red),
        .pix_cur  (cur1_reg.red),
        .residual (res_r)
    );

    lpp_chan_pred u_pred_green (
        .aclk     (aclk),
        .en       (en),
        .cfg      (pcfg_reg),
        .pix_l    (l1.green),
        .pix_u    (up1.green),
        .pix_ll   (ll1.green),
        .pix_ul   (ul1.green),
        .pix_uu   (uu1.green),
        .pix_ur   (ur1.green),
        .pix_cur  (cur1_reg.green),
        .residual (res_g)
    );

    lpp_chan_pred u_pred_blue (
        .aclk     (aclk),
        .en       (en),
        .cfg      (pcfg_reg),
        .pix_l    (l1.blue),
        .pix_u    (up1.blue),
        .pix_ll   (ll1.blue),
        .pix_ul   (ul1.blue),
        .pix_uu   (uu1.blue),
        .pix_ur   (ur1.blue),
        .pix_cur  (cur1_reg.blue),
        .residual (res_b)
    );

    // ---------------- output ----------------
    result_t res2;
    result_t m_data;

    always_comb begin
        res2           = '0;
        res2.res_red   = res_r;
        res2.res_green = res_g;
        res2.res_blue  = res_b;
        res2.col       = col2_reg;
        res2.row       = row2_reg;
    end

    lpp_out_skid u_out_skid (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (en && v2_reg),
        .push_data  (res2),
        .push_ready (en),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_data     (m_data)
    );

    assign m_tdata = 56'(m_data);

    // ---------------- assertions ----------------
    a_frame_start_col0: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && frame_start) |=> (v1_reg && col1_reg == '0))
        else $error("frame start item did not enter stage 1 at column 0");

    a_edge_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && v1_reg && !int1_reg) |=> !v2_reg)
        else $error("non-interior pixel produced a result");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!en && v1_reg) |=> (v1_reg && $stable(col1_reg) && $stable(cur1_reg)))
        else $error("stage 1 item changed while the pipeline was stalled");

endmodule

`default_nettype wire
